### rtl/assert_macros.svh
// Assertion macros for the RTL of the gamma correction core.
// Depends on nothing; empty bodies when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_AT(label, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

### rtl/gpa_pkg.sv
// Package of the gamma correction core: register map and fixed widths.
// Depends on nothing.
package gpa_pkg;
    localparam int COEFF_W  = 32;
    localparam int ACC_W    = 36;
    localparam int NUM_COEFF = 6;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;
    localparam logic [COEFF_W-1:0] COEFF1_RESET = 32'h0100_0000;

    typedef enum logic [2:0] {
        REG_ROOT_COUNT = 3'd0,
        REG_COEFF_0    = 3'd1,
        REG_COEFF_1    = 3'd2,
        REG_COEFF_2    = 3'd3,
        REG_COEFF_3    = 3'd4,
        REG_COEFF_4    = 3'd5,
        REG_COEFF_5    = 3'd6,
        REG_NONE       = 3'd7
    } reg_idx_t;
endpackage

### rtl/gamma_poly_approx_core.sv
// Gamma correction core: two pipelined square roots, five Horner stages, saturation.
// Depends on gpa_pkg and assert_macros.svh.
//
// Usage:
//  - Samples enter on the s_ stream (s_tdata low SAMPLE_BITS bits, s_tlast marks
//    the final sample of a frame). Results leave on the m_ stream with tlast copied.
//  - Registers on the APB port: root_count at 0x00, coeff_0..coeff_5 at 0x04..0x18.
//    Write them only while no sample is in flight.
//  - Throughput: one sample per clock unless the receiver stalls. The pipeline
//    holds 2*SAMPLE_BITS square root bit stages (one result bit per stage per
//    root), five Horner stages (one 36x(SAMPLE_BITS+1) multiply each) and one
//    output register, which a sample passes in that order.
//  - Both roots are always computed; root_count selects the Horner operand.
//  - Reset clears every valid bit and loads the identity polynomial.
//  - When the receiver stalls with a result held, the whole pipeline freezes
//    and s_tready drops in the same cycle; no request is lost or repeated.
`include "assert_macros.svh"
module gamma_poly_approx_core
    import gpa_pkg::*;
#(
    parameter int SAMPLE_BITS     = 16,
    parameter int COEFF_FRAC_BITS = 24
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,   // [SAMPLE_BITS-1:0] sample
    input  logic                 s_tlast,                // last_in
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_tdata,   // [SAMPLE_BITS-1:0] corrected
    output logic                 m_tlast,                // last_out
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);
    localparam int S      = SAMPLE_BITS;
    localparam int TD_W   = ((SAMPLE_BITS+7)/8)*8;
    localparam int NSQ    = 2*S;
    localparam int REM_W  = S+3;
    localparam int NHZ    = 5;
    localparam int RND_SH = (COEFF_FRAC_BITS > S) ? COEFF_FRAC_BITS - S : 1;
    localparam int LFT_SH = (COEFF_FRAC_BITS < S) ? S - COEFF_FRAC_BITS : 0;

    // ---------------- configuration registers ----------------
    logic [1:0]                root_count_reg;
    logic signed [COEFF_W-1:0] coeff_reg [NUM_COEFF];
    reg_idx_t                  reg_sel;
    logic                      wr_en;

    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_count_reg <= 2'd0;
            for (int i = 0; i < NUM_COEFF; i++) begin
                coeff_reg[i] <= (i == 1) ? COEFF1_RESET : '0;
            end
        end else if (wr_en) begin
            case (reg_sel)
                REG_ROOT_COUNT: root_count_reg <= pwdata[1:0];
                REG_COEFF_0:    coeff_reg[0] <= pwdata;
                REG_COEFF_1:    coeff_reg[1] <= pwdata;
                REG_COEFF_2:    coeff_reg[2] <= pwdata;
                REG_COEFF_3:    coeff_reg[3] <= pwdata;
                REG_COEFF_4:    coeff_reg[4] <= pwdata;
                REG_COEFF_5:    coeff_reg[5] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_ROOT_COUNT: prdata = {{(PDATA_W-2){1'b0}}, root_count_reg};
            REG_COEFF_0:    prdata = coeff_reg[0];
            REG_COEFF_1:    prdata = coeff_reg[1];
            REG_COEFF_2:    prdata = coeff_reg[2];
            REG_COEFF_3:    prdata = coeff_reg[3];
            REG_COEFF_4:    prdata = coeff_reg[4];
            REG_COEFF_5:    prdata = coeff_reg[5];
            default:        prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    // Advance everything when the output register is free or being drained.
    logic m_tvalid_reg;
    logic adv;
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    // ---------------- square root stages ----------------
    // Stages 0..S-1 take the first root, S..2S-1 the second; one bit each.
    logic             sq_vld_reg  [NSQ];
    logic [2*S-1:0]   sq_n_reg    [NSQ];
    logic [REM_W-1:0] sq_rem_reg  [NSQ];
    logic [S-1:0]     sq_root_reg [NSQ];
    logic [S-1:0]     sq_smp_reg  [NSQ];
    logic [S-1:0]     sq_r1_reg   [NSQ];
    logic             sq_last_reg [NSQ];

    for (genvar k = 0; k < NSQ; k++) begin : g_sq
        logic             vld_in, last_in;
        logic [2*S-1:0]   n_in;
        logic [REM_W-1:0] rem_in, rem_sh, trial, rem_next;
        logic [S-1:0]     root_in, smp_in, r1_in, root_next;

        if (k == 0) begin : g_head
            assign vld_in  = s_tvalid;
            assign last_in = s_tlast;
            assign smp_in  = s_tdata[S-1:0];
            assign n_in    = {s_tdata[S-1:0], {S{1'b0}}};
            assign rem_in  = '0;
            assign root_in = '0;
            assign r1_in   = '0;
        end else if (k == S) begin : g_second
            assign vld_in  = sq_vld_reg[k-1];
            assign last_in = sq_last_reg[k-1];
            assign smp_in  = sq_smp_reg[k-1];
            assign n_in    = {sq_root_reg[k-1], {S{1'b0}}};
            assign rem_in  = '0;
            assign root_in = '0;
            assign r1_in   = sq_root_reg[k-1];
        end else begin : g_chain
            assign vld_in  = sq_vld_reg[k-1];
            assign last_in = sq_last_reg[k-1];
            assign smp_in  = sq_smp_reg[k-1];
            assign n_in    = sq_n_reg[k-1];
            assign rem_in  = sq_rem_reg[k-1];
            assign root_in = sq_root_reg[k-1];
            assign r1_in   = sq_r1_reg[k-1];
        end

        always_comb begin
            rem_sh = {rem_in[REM_W-3:0], n_in[2*S-1:2*S-2]};
            trial  = {1'b0, root_in, 2'b01};
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_in[S-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_in[S-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_vld_reg[k] <= 1'b0;
            end else if (adv) begin
                sq_vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_n_reg[k]    <= {n_in[2*S-3:0], 2'b00};
                sq_rem_reg[k]  <= rem_next;
                sq_root_reg[k] <= root_next;
                sq_smp_reg[k]  <= smp_in;
                sq_r1_reg[k]   <= r1_in;
                sq_last_reg[k] <= last_in;
            end
        end
    end

    // Pick the Horner operand; a root count of three acts as two.
    logic [S-1:0] x_sel;
    always_comb begin
        case (root_count_reg)
            2'd0:    x_sel = sq_smp_reg[NSQ-1];
            2'd1:    x_sel = sq_r1_reg[NSQ-1];
            default: x_sel = sq_root_reg[NSQ-1];
        endcase
    end

    // ---------------- Horner stages ----------------
    logic                    hz_vld_reg  [NHZ];
    logic signed [ACC_W-1:0] hz_acc_reg  [NHZ];
    logic [S-1:0]            hz_x_reg    [NHZ];
    logic                    hz_last_reg [NHZ];

    for (genvar h = 0; h < NHZ; h++) begin : g_hz
        logic                    vld_in, last_in;
        logic signed [ACC_W-1:0] acc_in, acc_next;
        logic [S-1:0]            x_in;
        logic signed [ACC_W+S:0] prod, prod_sh;

        if (h == 0) begin : g_head
            assign vld_in  = sq_vld_reg[NSQ-1];
            assign last_in = sq_last_reg[NSQ-1];
            assign x_in    = x_sel;
            assign acc_in  = ACC_W'(coeff_reg[5]);
        end else begin : g_chain
            assign vld_in  = hz_vld_reg[h-1];
            assign last_in = hz_last_reg[h-1];
            assign x_in    = hz_x_reg[h-1];
            assign acc_in  = hz_acc_reg[h-1];
        end

        always_comb begin
            // floor(acc * x / 2^S) plus the next lower coefficient
            prod     = acc_in * $signed({1'b0, x_in});
            prod_sh  = prod >>> S;
            acc_next = prod_sh[ACC_W-1:0] + ACC_W'(coeff_reg[4-h]);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                hz_vld_reg[h] <= 1'b0;
            end else if (adv) begin
                hz_vld_reg[h] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                hz_acc_reg[h]  <= acc_next;
                hz_x_reg[h]    <= x_in;
                hz_last_reg[h] <= last_in;
            end
        end
    end

    // ---------------- rounding and saturation ----------------
    logic signed [ACC_W-1:0] acc_fin;
    logic [ACC_W-1:0]        u_val;
    logic [S-1:0]            corr_next;
    assign acc_fin = hz_acc_reg[NHZ-1];

    always_comb begin
        u_val = acc_fin;
        if (COEFF_FRAC_BITS > S) begin
            u_val = (acc_fin + (ACC_W'(1) << (RND_SH-1))) >> RND_SH;
        end else if (COEFF_FRAC_BITS < S) begin
            if (acc_fin >= (ACC_W'(1) << (COEFF_FRAC_BITS+1))) begin
                u_val = ACC_W'({S{1'b1}});
            end else begin
                u_val = acc_fin << LFT_SH;
            end
        end
        if (acc_fin <= 0) begin
            corr_next = '0;
        end else if (u_val > ACC_W'({S{1'b1}})) begin
            corr_next = '1;
        end else begin
            corr_next = u_val[S-1:0];
        end
    end

    // ---------------- output register ----------------
    logic [S-1:0] m_corr_reg;
    logic         m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= hz_vld_reg[NHZ-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_corr_reg <= corr_next;
            m_last_reg <= hz_last_reg[NHZ-1];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TD_W'(m_corr_reg);
    assign m_tlast  = m_last_reg;

    // ---------------- assertions ----------------
    // Squares around the first root, for the bound checks below.
    logic [2*S+1:0] r1_arg, r1_val, r1_up, r1_sq, r1_up_sq;
    assign r1_arg   = (2*S+2)'({sq_smp_reg[S-1], {S{1'b0}}});
    assign r1_val   = (2*S+2)'(sq_root_reg[S-1]);
    assign r1_up    = r1_val + (2*S+2)'(1);
    assign r1_sq    = r1_val * r1_val;
    assign r1_up_sq = r1_up * r1_up;

    `ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid_reg, "output valid after reset")
    `ASSERT_AT(a_stall_freezes, aclk, aresetn, !adv |=> $stable(hz_vld_reg[NHZ-1]), "pipe moved")
    `ASSERT_AT(a_root1_floor, aclk, aresetn, sq_vld_reg[S-1] |-> r1_sq <= r1_arg, "root too large")
    `ASSERT_AT(a_root1_tight, aclk, aresetn, sq_vld_reg[S-1] |-> r1_up_sq > r1_arg, "root too small")
endmodule
